/* rtl/isoms_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isoms_pkg: shared types and constants for the timestamp converter
// Record passed from the character parser to the conversion sequencer,
// queue status, sequencer states and the small calendar tables.
// ----------------------------------------------------------------------------
package isoms_pkg;

    // text layout
    localparam logic [4:0] TEXT_LEN = 5'd24;
    localparam logic [4:0] LAST_POS = 5'd23;

    // field boundaries (first position after each field)
    localparam logic [4:0] YEAR_END   = 5'd4;
    localparam logic [4:0] MONTH_END  = 5'd7;
    localparam logic [4:0] DAY_END    = 5'd10;
    localparam logic [4:0] HOUR_END   = 5'd13;
    localparam logic [4:0] MINUTE_END = 5'd16;
    localparam logic [4:0] SECOND_END = 5'd19;

    // characters
    localparam logic [7:0] NO_SEP   = 8'h00;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // calendar and time constants
    localparam logic [13:0] MIN_YEAR      = 14'd1970;
    localparam logic [23:0] DAYS_PER_ERA  = 24'd146097;
    localparam logic [23:0] EPOCH_SHIFT   = 24'd719468;
    localparam logic [26:0] MS_PER_DAY    = 27'd86400000;
    localparam logic [28:0] MS_PER_HOUR   = 29'd3600000;
    localparam logic [28:0] MS_PER_MINUTE = 29'd60000;
    localparam logic [16:0] MS_PER_SECOND = 17'd1000;

    // reciprocals for division by constants
    localparam logic [17:0] K_DIV100   = 18'd167773;  // 2^24 / 100, rounded up
    localparam int          SH_DIV100  = 24;
    localparam logic [12:0] K_DIV400   = 13'd5243;    // 2^21 / 400, rounded up
    localparam int          SH_DIV400  = 21;
    localparam logic [14:0] K_YOE100   = 15'd41;      // 2^12 / 100, rounded up
    localparam int          SH_YOE100  = 12;

    // queue between parser and sequencer
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic        bad;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [9:0]  milli;
    } ts_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DIV100,
        BK_DIV400,
        BK_CHECK,
        BK_DOE,
        BK_DAYS,
        BK_DAYMS,
        BK_SUM,
        BK_DONE
    } bk_state_t;

    // separator expected at a position, NO_SEP where a digit belongs
    function automatic logic [7:0] sep_at(input logic [4:0] p);
        logic [7:0] s;
        unique case (p)
            5'd4, 5'd7:   s = CH_DASH;
            5'd10:        s = CH_T;
            5'd13, 5'd16: s = CH_COLON;
            5'd19:        s = CH_DOT;
            5'd23:        s = CH_Z;
            default:      s = NO_SEP;
        endcase
        return s;
    endfunction

    // days before a month, months counted from march
    function automatic logic [8:0] month_offset(input logic [3:0] mp);
        logic [8:0] o;
        unique case (mp)
            4'd0:    o = 9'd0;
            4'd1:    o = 9'd31;
            4'd2:    o = 9'd61;
            4'd3:    o = 9'd92;
            4'd4:    o = 9'd122;
            4'd5:    o = 9'd153;
            4'd6:    o = 9'd184;
            4'd7:    o = 9'd214;
            4'd8:    o = 9'd245;
            4'd9:    o = 9'd275;
            4'd10:   o = 9'd306;
            4'd11:   o = 9'd337;
            default: o = 9'd0;
        endcase
        return o;
    endfunction

    // length of a month, zero for a month outside 1..12
    function automatic logic [4:0] month_days(input logic [6:0] m, input logic leap);
        logic [4:0] n;
        unique case (m)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: n = 5'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                    n = 5'd30;
            7'd2:                                       n = leap ? 5'd29 : 5'd28;
            default:                                    n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

/* rtl/iso8601_timestamp_to_epoch_ms.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso8601_timestamp_to_epoch_ms: UTC timestamp text to Unix milliseconds
// Parses YYYY-MM-DDTHH:MM:SS.mmmZ one character per transfer and returns a
// valid flag and the milliseconds since 1970-01-01 for each final character.
// ----------------------------------------------------------------------------
//
//  channel | signals                         | dir | transfer when
//  --------+---------------------------------+-----+--------------------------
//  input   | in_valid, char_code, last_char  | in  | in_valid && !in_stall
//          | in_stall                        | out |
//  output  | out_valid, valid_res, unix_ms   | out | out_valid && !out_stall
//          | out_stall                       | in  |
//
//  one character is taken per cycle while in_stall is low; in_stall rises only
//  while the record queue is full
//  each final character queues one record; the sequencer takes it from the
//  queue, runs 7 arithmetic steps and loads the result into the output
//  register
//  reset clears the parser position, accumulators, queue pointers, sequencer
//  state and the output valid flag
//  a stalled output holds its register; the sequencer waits in its last step
//  and the parser keeps taking characters until the queue fills
//
module iso8601_timestamp_to_epoch_ms
    import isoms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        valid_res,
    output logic [47:0] unix_ms
);

    // parser to queue
    q_status_t q_stat;
    logic      q_push;
    ts_rec_t   q_wr_rec;

    // queue to sequencer
    logic      q_pop;
    ts_rec_t   q_rd_rec;

    // front: position checks and decimal accumulation
    isoms_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .last_char (last_char),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_rec     (q_wr_rec)
    );

    // decouples the parser from the slower per-record conversion
    isoms_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_rec (q_wr_rec),
        .pop    (q_pop),
        .rd_rec (q_rd_rec),
        .stat   (q_stat)
    );

    // back: range checks, days from civil date, milliseconds
    isoms_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_rec     (q_rd_rec),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .valid_res (valid_res),
        .unix_ms   (unix_ms)
    );

`ifndef ASSERT_OFF
    // a final character is never taken while the queue has no room
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("record pushed into a full queue");

    // the sequencer only takes a record that is there
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("record popped from an empty queue");

    // an invalid timestamp always reports zero milliseconds
    a_zero_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |-> (unix_ms == 48'd0))
        else $error("invalid result with nonzero milliseconds");
`endif

endmodule

/* rtl/isoms_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isoms_front: character parser
// Checks each character against its position, accumulates the decimal
// fields and pushes one record into the queue on the final character.
// ----------------------------------------------------------------------------
module isoms_front
    import isoms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       last_char,
    input  q_status_t  q_stat,
    output logic       q_push,
    output ts_rec_t    q_rec
);

    logic [4:0]  pos_reg, pos_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  month_reg, month_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  minute_reg, minute_next;
    logic [6:0]  second_reg, second_next;
    logic [9:0]  milli_reg, milli_next;
    logic        bad_reg, bad_next;

    logic        in_accept;
    logic [7:0]  sep;
    logic        is_digit;
    logic [3:0]  digit;
    logic        char_bad;

    assign in_stall  = q_stat.full;
    assign in_accept = in_valid && !in_stall;

    assign sep      = sep_at(pos_reg);
    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign digit    = 4'(char_code - CH_ZERO);
    assign char_bad = (pos_reg >= TEXT_LEN) ||
                      ((sep != NO_SEP) ? (char_code != sep) : !is_digit);

    // the final separator never accumulates, so a good text is complete in the regs
    assign q_rec.bad    = bad_reg || char_bad || (pos_reg != LAST_POS);
    assign q_rec.year   = year_reg;
    assign q_rec.month  = month_reg;
    assign q_rec.day    = day_reg;
    assign q_rec.hour   = hour_reg;
    assign q_rec.minute = minute_reg;
    assign q_rec.second = second_reg;
    assign q_rec.milli  = milli_reg;
    assign q_push       = in_accept && last_char;

    always_comb
    begin
        pos_next    = pos_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        milli_next  = milli_reg;
        bad_next    = bad_reg;
        if (in_accept)
        begin
            if (char_bad)
            begin
                bad_next = 1'b1;
            end
            if (pos_reg < TEXT_LEN)
            begin
                pos_next = pos_reg + 5'd1;
            end
            if (!char_bad && sep == NO_SEP)
            begin
                priority if (pos_reg < YEAR_END)
                    year_next = 14'(year_reg * 14'd10 + 14'(digit));
                else if (pos_reg < MONTH_END)
                    month_next = 7'(month_reg * 7'd10 + 7'(digit));
                else if (pos_reg < DAY_END)
                    day_next = 7'(day_reg * 7'd10 + 7'(digit));
                else if (pos_reg < HOUR_END)
                    hour_next = 7'(hour_reg * 7'd10 + 7'(digit));
                else if (pos_reg < MINUTE_END)
                    minute_next = 7'(minute_reg * 7'd10 + 7'(digit));
                else if (pos_reg < SECOND_END)
                    second_next = 7'(second_reg * 7'd10 + 7'(digit));
                else
                    milli_next = 10'(milli_reg * 10'd10 + 10'(digit));
            end
            // end of text: start over
            if (last_char)
            begin
                pos_next    = '0;
                year_next   = '0;
                month_next  = '0;
                day_next    = '0;
                hour_next   = '0;
                minute_next = '0;
                second_next = '0;
                milli_next  = '0;
                bad_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            year_reg   <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
            milli_reg  <= '0;
            bad_reg    <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            milli_reg  <= milli_next;
            bad_reg    <= bad_next;
        end
    end

endmodule

/* rtl/isoms_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isoms_queue: record queue
// Short first-in first-out buffer of parsed timestamps between the parser
// and the conversion sequencer.
// ----------------------------------------------------------------------------
module isoms_queue
    import isoms_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  ts_rec_t   wr_rec,
    input  logic      pop,
    output ts_rec_t   rd_rec,
    output q_status_t stat
);

    ts_rec_t           mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]     count_reg, count_next;

    assign stat.full  = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rd_rec     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + (Q_AW+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (Q_AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

endmodule

/* rtl/isoms_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isoms_back: conversion sequencer
// Takes one record at a time, checks the field ranges and builds the epoch
// milliseconds over a fixed sequence of steps into an output register.
// ----------------------------------------------------------------------------
module isoms_back
    import isoms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_status_t   q_stat,
    input  ts_rec_t     q_rec,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        valid_res,
    output logic [47:0] unix_ms
);

    bk_state_t   state_reg, state_next;
    logic        out_valid_reg;
    logic        valid_res_reg;
    logic [47:0] unix_ms_reg;
    logic        out_free;
    logic        load_out;

    ts_rec_t     rec_reg;
    logic [13:0] yy_reg;
    logic [3:0]  mp_reg;
    logic [7:0]  q100_reg;
    logic [5:0]  era_reg;
    logic        leap_reg;
    logic        ok_reg;
    logic [8:0]  yoe_reg;
    logic [8:0]  doy_reg;
    logic [17:0] doe_reg;
    logic [21:0] days_reg;
    logic [26:0] hm_reg;
    logic [16:0] sms_reg;
    logic [47:0] dayms_reg;
    logic [47:0] total_reg;

    logic        r100_zero;
    logic [2:0]  yoe_c100;

    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:   if (!q_stat.empty) state_next = BK_DIV100;
            BK_DIV100: state_next = BK_DIV400;
            BK_DIV400: state_next = BK_CHECK;
            BK_CHECK:  state_next = BK_DOE;
            BK_DOE:    state_next = BK_DAYS;
            BK_DAYS:   state_next = BK_DAYMS;
            BK_DAYMS:  state_next = BK_SUM;
            BK_SUM:    state_next = BK_DONE;
            BK_DONE:   if (out_free) state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            BK_IDLE: q_pop    = !q_stat.empty;
            BK_DONE: load_out = out_free;
            default:
            begin
                q_pop    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // year mod 100 from the quotient by 100, and year of era divided by 100
    assign r100_zero = (rec_reg.year == 14'(16'(q100_reg) * 16'd100));
    assign yoe_c100  = 3'((15'(yoe_reg) * K_YOE100) >> SH_YOE100);

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rec_reg <= q_rec;
        end
        if (load_out)
        begin
            valid_res_reg <= ok_reg;
            unix_ms_reg   <= ok_reg ? total_reg : '0;
        end
        unique case (state_reg)
            BK_DIV100:
            begin
                q100_reg <= 8'((32'(rec_reg.year) * 32'(K_DIV100)) >> SH_DIV100);
                yy_reg   <= (rec_reg.month <= 7'd2) ? rec_reg.year - 14'd1 : rec_reg.year;
                mp_reg   <= (rec_reg.month > 7'd2) ? 4'(rec_reg.month - 7'd3)
                                                   : 4'(rec_reg.month + 7'd9);
            end
            BK_DIV400:
            begin
                era_reg  <= 6'((27'(yy_reg) * 27'(K_DIV400)) >> SH_DIV400);
                leap_reg <= (rec_reg.year[1:0] == 2'd0) && (!r100_zero || q100_reg[1:0] == 2'd0);
            end
            BK_CHECK:
            begin
                ok_reg  <= !rec_reg.bad && (rec_reg.year >= MIN_YEAR) &&
                           (rec_reg.month >= 7'd1) && (rec_reg.month <= 7'd12) &&
                           (rec_reg.day >= 7'd1) &&
                           (rec_reg.day <= 7'(month_days(rec_reg.month, leap_reg))) &&
                           (rec_reg.hour <= 7'd23) && (rec_reg.minute <= 7'd59) &&
                           (rec_reg.second <= 7'd59);
                yoe_reg <= 9'(yy_reg - 14'(15'(era_reg) * 15'd400));
                doy_reg <= 9'(month_offset(mp_reg) + 9'(rec_reg.day) - 9'd1);
            end
            BK_DOE:
            begin
                doe_reg <= 18'(18'(yoe_reg) * 18'd365 + 18'(yoe_reg >> 2) -
                               18'(yoe_c100) + 18'(doy_reg));
            end
            BK_DAYS:
            begin
                days_reg <= 22'(24'(era_reg) * DAYS_PER_ERA + 24'(doe_reg) - EPOCH_SHIFT);
                hm_reg   <= 27'(29'(rec_reg.hour) * MS_PER_HOUR +
                                29'(rec_reg.minute) * MS_PER_MINUTE);
            end
            BK_DAYMS:
            begin
                dayms_reg <= 48'(49'(days_reg) * 49'(MS_PER_DAY));
                sms_reg   <= 17'(17'(rec_reg.second) * MS_PER_SECOND + 17'(rec_reg.milli));
            end
            BK_SUM:
            begin
                total_reg <= dayms_reg + 48'(hm_reg) + 48'(sms_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign valid_res = valid_res_reg;
    assign unix_ms   = unix_ms_reg;

endmodule

/* bench/iso8601_timestamp_to_epoch_ms_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso8601_timestamp_to_epoch_ms_tb: bench for the timestamp text converter
// Streams timestamp texts one character per transfer, predicts the valid
// flag and epoch milliseconds of every final character and checks each
// result transfer in order, with bursty input and random output stalls.
// ----------------------------------------------------------------------------
module iso8601_timestamp_to_epoch_ms_tb;
    import isoms_pkg::*;

    typedef logic [7:0] char_q_t[$];

    // expected results of the character stream, oldest first
    class timestamp_scoreboard;
        logic [4:0]  pos;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [9:0]  milli;
        logic        bad;
        logic        want_ok[$];
        logic [47:0] want_ms[$];
        int          mismatches;

        function new();
            clear_text();
            mismatches = 0;
        endfunction

        function void clear_text();
            pos    = '0;
            year   = '0;
            month  = '0;
            day    = '0;
            hour   = '0;
            minute = '0;
            second = '0;
            milli  = '0;
            bad    = 1'b0;
        endfunction

        function int pending();
            return want_ok.size();
        endfunction

        // separator a position calls for, NO_SEP where a digit belongs
        function logic [7:0] separator_for(logic [4:0] p);
            case (p)
                YEAR_END, MONTH_END:    return CH_DASH;
                DAY_END:                return CH_T;
                HOUR_END, MINUTE_END:   return CH_COLON;
                SECOND_END:             return CH_DOT;
                LAST_POS:               return CH_Z;
                default:                return NO_SEP;
            endcase
        endfunction

        function void add_digit(logic [4:0] p, logic [3:0] dg);
            if (p < YEAR_END)        year   = 14'(year * 14'd10 + 14'(dg));
            else if (p < MONTH_END)  month  = 7'(month * 7'd10 + 7'(dg));
            else if (p < DAY_END)    day    = 7'(day * 7'd10 + 7'(dg));
            else if (p < HOUR_END)   hour   = 7'(hour * 7'd10 + 7'(dg));
            else if (p < MINUTE_END) minute = 7'(minute * 7'd10 + 7'(dg));
            else if (p < SECOND_END) second = 7'(second * 7'd10 + 7'(dg));
            else                     milli  = 10'(milli * 10'd10 + 10'(dg));
        endfunction

        function int unsigned month_length(int unsigned y, int unsigned m);
            bit leap;
            leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
            case (m)
                1, 3, 5, 7, 8, 10, 12: return 31;
                4, 6, 9, 11:           return 30;
                2:                     return leap ? 29 : 28;
                default:               return 0;
            endcase
        endfunction

        // days since 1970-01-01, years counted from march in 400-year eras
        function longint unsigned epoch_days(int unsigned y, int unsigned m,
                                             int unsigned d);
            int unsigned yy, era, yoe, mp, doy, doe;
            yy  = (m <= 2) ? y - 1 : y;
            era = yy / 400;
            yoe = yy - era * 400;
            mp  = (m > 2) ? m - 3 : m + 9;
            doy = (153 * mp + 2) / 5 + d - 1;
            doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            return longint'(era) * 146097 + doe - 719468;
        endfunction

        // one accepted character; a final character queues one expectation
        function void take_char(logic [7:0] c, logic fin);
            logic [4:0]      p;
            logic [7:0]      sep;
            logic            ok;
            longint unsigned ms;
            p  = pos;
            ms = 0;
            if (p >= TEXT_LEN)
            begin
                bad = 1'b1;
            end
            else
            begin
                sep = separator_for(p);
                if (sep != NO_SEP)
                begin
                    if (c != sep)
                        bad = 1'b1;
                end
                else if (c >= CH_ZERO && c <= CH_NINE)
                begin
                    add_digit(p, 4'(c - CH_ZERO));
                end
                else
                begin
                    bad = 1'b1;
                end
                pos = p + 5'd1;
            end
            if (!fin)
                return;
            ok = !bad && (p == LAST_POS) && (year >= MIN_YEAR) &&
                 (month >= 1) && (month <= 12) && (day >= 1) &&
                 (day <= month_length(year, month)) &&
                 (hour <= 23) && (minute <= 59) && (second <= 59);
            if (ok)
                ms = epoch_days(year, month, day) * 64'(MS_PER_DAY) +
                     64'(hour) * 64'(MS_PER_HOUR) +
                     64'(minute) * 64'(MS_PER_MINUTE) +
                     64'(second) * 64'(MS_PER_SECOND) + 64'(milli);
            want_ok.push_back(ok);
            want_ms.push_back(ms[47:0]);
            clear_text();
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void check_reading(logic vres, logic [47:0] ms);
            logic        eok;
            logic [47:0] ems;
            if (want_ok.size() == 0)
            begin
                note_mismatch($sformatf("unexpected result valid_res %0b unix_ms %0d",
                                        vres, ms));
                return;
            end
            eok = want_ok.pop_front();
            ems = want_ms.pop_front();
            if (vres !== eok || ms !== ems)
                note_mismatch($sformatf("expected valid_res %0b unix_ms %0d, got %0b %0d",
                                        eok, ems, vres, ms));
        endfunction
    endclass

    localparam int CHAR_TARGET = 1850;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  char_code = 8'h00;
    logic        last_char = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        valid_res;
    logic [47:0] unix_ms;

    timestamp_scoreboard sb;
    int burst_left = 0;
    int chars_sent = 0;
    int cycles = 0;
    int stall_mode = 0;
    int stall_timer = 0;

    iso8601_timestamp_to_epoch_ms u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .valid_res (valid_res),
        .unix_ms   (unix_ms)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // output side: check each result transfer, then pick the next stall
    // the stall mode changes when its random timer runs out so that long free
    // stretches, light and heavy random stalls and long stall runs all occur
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_reading(valid_res, unix_ms);
        if (stall_timer == 0)
        begin
            stall_mode  = $urandom_range(0, 3);
            stall_timer = $urandom_range(20, 300);
        end
        else
        begin
            stall_timer--;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= stall_timer[3];
        endcase
    end

    // one character transfer; the sender runs in bursts with idle gaps
    // valid stays high between characters of a burst and is lowered only at a gap or
    // while the sender holds off, so it never gets two assignments in one time step
    task automatic send_char(input logic [7:0] c, input logic fin);
        int gap;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        last_char <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_char(c, fin);
        burst_left--;
        chars_sent++;
    endtask

    task automatic send_text(input char_q_t t);
        for (int i = 0; i < t.size(); i++)
            send_char(t[i], i == t.size() - 1);
    endtask

    // sender holds off until every expected result has come back
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic char_q_t to_chars(string s);
        char_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    // mostly inside the legal range, sometimes outside it
    function automatic int pick_field(int lo, int hi, int bad_lo, int bad_hi);
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(lo, hi);
        return $urandom_range(bad_lo, bad_hi);
    endfunction

    // well-formed texts with random fields, mixed with damaged ones and noise
    task automatic send_random_text();
        char_q_t t;
        int      kind, y, mo, d, cut;
        int      sep_pos[7] = '{4, 7, 10, 13, 16, 19, 23};
        kind = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0:       y = $urandom_range(0, 9999);
            1:       y = ($urandom_range(0, 1) == 1) ? 2000 : 2100;
            2:       y = 1968 + 4 * $urandom_range(0, 110);
            default: y = $urandom_range(1965, 2500);
        endcase
        mo = ($urandom_range(0, 3) == 0) ? 2 : pick_field(1, 12, 0, 99);
        d  = ($urandom_range(0, 2) == 0) ? $urandom_range(28, 31)
                                         : pick_field(1, 28, 0, 99);
        t = to_chars($sformatf("%04d-%02d-%02dT%02d:%02d:%02d.%03dZ", y, mo, d,
                               pick_field(0, 23, 24, 99), pick_field(0, 59, 60, 99),
                               pick_field(0, 59, 60, 99), $urandom_range(0, 999)));
        if (kind >= 70 && kind < 78)
        begin
            t[$urandom_range(0, 23)] = 8'($urandom_range(0, 255));
        end
        else if (kind >= 78 && kind < 84)
        begin
            cut = $urandom_range(1, 23);
            while (t.size() > cut)
                void'(t.pop_back());
        end
        else if (kind >= 84 && kind < 89)
        begin
            repeat ($urandom_range(1, 6)) t.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind >= 89 && kind < 95)
        begin
            t.delete();
            repeat ($urandom_range(1, 30)) t.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind >= 95)
        begin
            t[sep_pos[$urandom_range(0, 6)]] = 8'(CH_ZERO + $urandom_range(0, 9));
        end
        send_text(t);
    endtask

    initial
    begin
        string   directed[$];
        char_q_t raw;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes, calendar corners and each malformed shape
        directed = '{
            "1970-01-01T00:00:00.000Z",     // epoch itself
            "9999-12-31T23:59:59.999Z",     // largest value
            "2000-02-29T12:34:56.789Z",     // leap day in a 400-year
            "2100-02-29T00:00:00.000Z",     // century that is no leap year
            "2024-02-29T23:59:59.999Z",
            "2023-02-29T00:00:00.000Z",
            "1969-12-31T23:59:59.999Z",     // year before the epoch
            "2021-00-10T00:00:00.000Z",
            "2021-13-10T00:00:00.000Z",
            "2021-04-31T00:00:00.000Z",
            "2021-04-00T00:00:00.000Z",
            "2021-05-05T24:00:00.000Z",
            "2021-05-05T23:60:00.000Z",
            "2021-05-05T23:59:60.000Z",
            "2021-05-05T23:59:59.000",      // one short
            "2021-05-05T23:59:59.000Z00",   // past the end
            "2021/05-05T23:59:59.000Z",     // wrong separator
            "20a1-05-05T23:59:59.000Z",     // letter where a digit goes
            "2021-05-05T23:59:59.000z",
            "Z"
        };
        foreach (directed[i])
            send_text(to_chars(directed[i]));
        raw = '{8'h00, 8'hFF, 8'h80, 8'h7F};
        send_text(raw);
        hold_until_drained();

        while (chars_sent < CHAR_TARGET)
        begin
            send_random_text();
            if ($urandom_range(0, 24) == 0)
                hold_until_drained();
        end

        hold_until_drained();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/isoms_pkg.sv
rtl/isoms_front.sv
rtl/isoms_queue.sv
rtl/isoms_back.sv
rtl/iso8601_timestamp_to_epoch_ms.sv
bench/iso8601_timestamp_to_epoch_ms_tb.sv
